// ----- rtl/lbsd_pkg.sv -----
// ----------------------------------------------------------------------------
// LED blink shift driver package
// Shared constants, command codes, beat payloads and control structs.
// ----------------------------------------------------------------------------
package lbsd_pkg;

    localparam int LED_COUNT  = 32;
    localparam int BANK_WIDTH = 16;
    localparam int CHIP_WIDTH = 8;
    localparam int WORD_W     = 16;
    localparam int FRAME_W    = 2 * WORD_W;
    localparam int CNT_W      = $clog2(FRAME_W);
    localparam int BIT_IDX_W  = $clog2(BANK_WIDTH);
    localparam logic [WORD_W-1:0] WORD_MASK = 16'hFFFF;

    typedef enum logic [3:0] {
        OP_LIGHT     = 4'd0,
        OP_DARK      = 4'd1,
        OP_TOGGLE    = 4'd2,
        OP_BLINK     = 4'd3,
        OP_CLEAR     = 4'd4,
        OP_LOAD_LIT  = 4'd5,
        OP_LOAD_ALL  = 4'd6,
        OP_TICK      = 4'd7,
        OP_REFRESH   = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_LATCH
    } state_t;

    typedef struct packed {
        logic [3:0]        op;
        logic [5:0]        led_index;
        logic [WORD_W-1:0] left_word;
        logic [WORD_W-1:0] right_word;
        logic [WORD_W-1:0] left_blink_word;
        logic [WORD_W-1:0] right_blink_word;
    } in_item_t;

    typedef struct packed {
        logic               frame_valid;
        logic [FRAME_W-1:0] frame_word;
        logic               blink_phase;
        logic [WORD_W-1:0]  left_blink_mask;
        logic [WORD_W-1:0]  right_blink_mask;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic shift;
        logic latch;
    } ctrl_cmd_t;

    typedef struct packed {
        logic frame_req;
        logic out_free;
    } dp_status_t;

    // Chain order: right high, right low, left high, left low.
    function automatic logic [FRAME_W-1:0] make_frame(
        input logic [WORD_W-1:0] right_lit,
        input logic [WORD_W-1:0] left_lit
    );
        make_frame = {right_lit[2*CHIP_WIDTH-1:CHIP_WIDTH], right_lit[CHIP_WIDTH-1:0],
                      left_lit[2*CHIP_WIDTH-1:CHIP_WIDTH], left_lit[CHIP_WIDTH-1:0]};
    endfunction

endpackage

// ----- rtl/lbsd_if.sv -----
// ----------------------------------------------------------------------------
// LED blink shift driver channels
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface lbsd_in_if;
    import lbsd_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lbsd_out_if;
    import lbsd_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/lbsd_datapath.sv -----
// ----------------------------------------------------------------------------
// LED blink shift driver datapath
// LED state registers, command update, shift chain and output register.
// ----------------------------------------------------------------------------
module lbsd_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lbsd_pkg::in_item_t     item,
    input  lbsd_pkg::ctrl_cmd_t    cmd,
    output lbsd_pkg::dp_status_t   status,
    lbsd_out_if.source             result
);
    import lbsd_pkg::*;

    logic [WORD_W-1:0]  left_lit_reg, right_lit_reg, left_blink_reg, right_blink_reg;
    logic               phase_reg;
    logic [FRAME_W-1:0] shift_reg;
    logic [FRAME_W-1:0] capture_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic [WORD_W-1:0]  left_lit_next, right_lit_next, left_blink_next, right_blink_next;
    logic               phase_next;
    logic               frame_req;
    logic [5:0]         led_k;
    logic               idx_ok;
    logic               to_right;
    logic [WORD_W-1:0]  bit_mask;
    logic [WORD_W-1:0]  lit_sel, blk_sel;

    always_comb
    begin
        led_k    = item.led_index - 6'd1;
        idx_ok   = (item.led_index != 6'd0) && (item.led_index <= 6'(LED_COUNT));
        to_right = led_k >= 6'(BANK_WIDTH);
        bit_mask = WORD_W'(1) << led_k[BIT_IDX_W-1:0];
        lit_sel  = to_right ? right_lit_reg : left_lit_reg;
        blk_sel  = to_right ? right_blink_reg : left_blink_reg;

        left_lit_next    = left_lit_reg;
        right_lit_next   = right_lit_reg;
        left_blink_next  = left_blink_reg;
        right_blink_next = right_blink_reg;
        phase_next       = phase_reg;
        frame_req        = 1'b0;

        case (op_t'(item.op))
            OP_LIGHT, OP_DARK, OP_TOGGLE, OP_BLINK:
            begin
                case (op_t'(item.op))
                    OP_LIGHT:
                    begin
                        lit_sel = lit_sel | bit_mask;
                        blk_sel = blk_sel & ~bit_mask;
                    end
                    OP_DARK:
                    begin
                        lit_sel = lit_sel & ~bit_mask;
                        blk_sel = blk_sel & ~bit_mask;
                    end
                    OP_TOGGLE:
                    begin
                        lit_sel = lit_sel ^ bit_mask;
                        blk_sel = blk_sel & ~bit_mask;
                    end
                    default:
                    begin
                        blk_sel = blk_sel | bit_mask;
                    end
                endcase
                if (idx_ok)
                begin
                    if (to_right)
                    begin
                        right_lit_next   = lit_sel;
                        right_blink_next = blk_sel;
                    end
                    else
                    begin
                        left_lit_next   = lit_sel;
                        left_blink_next = blk_sel;
                    end
                end
            end
            OP_CLEAR:
            begin
                left_lit_next    = '0;
                right_lit_next   = '0;
                left_blink_next  = '0;
                right_blink_next = '0;
                phase_next       = 1'b0;
                frame_req        = 1'b1;
            end
            OP_LOAD_LIT:
            begin
                left_lit_next    = item.left_word;
                right_lit_next   = item.right_word;
                left_blink_next  = left_blink_reg & (WORD_MASK ^ item.left_word);
                right_blink_next = right_blink_reg & (WORD_MASK ^ item.right_word);
            end
            OP_LOAD_ALL:
            begin
                left_lit_next    = item.left_word;
                right_lit_next   = item.right_word;
                left_blink_next  = item.left_blink_word;
                right_blink_next = item.right_blink_word;
            end
            OP_TICK:
            begin
                if ((left_blink_reg != '0) || (right_blink_reg != '0))
                begin
                    if (phase_reg)
                    begin
                        left_lit_next  = left_lit_reg | left_blink_reg;
                        right_lit_next = right_lit_reg | right_blink_reg;
                    end
                    else
                    begin
                        left_lit_next  = left_lit_reg & (WORD_MASK ^ left_blink_reg);
                        right_lit_next = right_lit_reg & (WORD_MASK ^ right_blink_reg);
                    end
                    phase_next = ~phase_reg;
                    frame_req  = 1'b1;
                end
            end
            OP_REFRESH:
            begin
                frame_req = 1'b1;
            end
            default:
            begin
                frame_req = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_lit_reg    <= '0;
            right_lit_reg   <= '0;
            left_blink_reg  <= '0;
            right_blink_reg <= '0;
            phase_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                left_lit_reg    <= left_lit_next;
                right_lit_reg   <= right_lit_next;
                left_blink_reg  <= left_blink_next;
                right_blink_reg <= right_blink_next;
                phase_reg       <= phase_next;
            end
            if ((cmd.accept && !frame_req) || cmd.latch)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Shift chain: serialize MSB first, reassemble at the far end.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && frame_req)
            shift_reg <= make_frame(right_lit_next, left_lit_next);
        else if (cmd.shift)
        begin
            shift_reg   <= {shift_reg[FRAME_W-2:0], 1'b0};
            capture_reg <= {capture_reg[FRAME_W-2:0], shift_reg[FRAME_W-1]};
        end

        if (cmd.accept && !frame_req)
        begin
            out_data_reg.frame_valid      <= 1'b0;
            out_data_reg.frame_word       <= '0;
            out_data_reg.blink_phase      <= phase_next;
            out_data_reg.left_blink_mask  <= left_blink_next;
            out_data_reg.right_blink_mask <= right_blink_next;
        end
        else if (cmd.latch)
        begin
            out_data_reg.frame_valid      <= 1'b1;
            out_data_reg.frame_word       <= capture_reg;
            out_data_reg.blink_phase      <= phase_reg;
            out_data_reg.left_blink_mask  <= left_blink_reg;
            out_data_reg.right_blink_mask <= right_blink_reg;
        end
    end

    assign status.frame_req = frame_req;
    assign status.out_free  = !out_valid_reg || result.ready;
    assign result.valid     = out_valid_reg;
    assign result.data      = out_data_reg;

endmodule

// ----- rtl/lbsd_ctrl.sv -----
// ----------------------------------------------------------------------------
// LED blink shift driver controller
// Sequences accept, 32-bit shift and latch of each frame.
// ----------------------------------------------------------------------------
module lbsd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lbsd_pkg::dp_status_t  status,
    output lbsd_pkg::ctrl_cmd_t   cmd
);
    import lbsd_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = status.out_free;
                cmd.accept = in_valid && status.out_free;
                if (cmd.accept && status.frame_req)
                begin
                    state_next = ST_SHIFT;
                    cnt_next   = '0;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (cnt_reg == CNT_W'(FRAME_W - 1))
                    state_next = ST_LATCH;
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_LATCH:
            begin
                // Hold off the latch pulse until the output register is free.
                cmd.latch = status.out_free;
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE)
        else $error("ready raised outside idle");
    a_frame_starts_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && status.frame_req) |=> (state_reg == ST_SHIFT && cnt_reg == '0))
        else $error("frame beat did not start the shift");
    a_shift_ends_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && cnt_reg == CNT_W'(FRAME_W - 1)) |=> state_reg == ST_LATCH)
        else $error("shift did not end in latch");
    a_latch_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LATCH && !status.out_free) |=> state_reg == ST_LATCH)
        else $error("latch dropped while output busy");
`endif

endmodule

// ----- rtl/led_blink_shift_driver_core.sv -----
// A command without a frame gives its result beat in the cycle after acceptance; a
// frame command (clear all, refresh, effective tick) gives it once shifted and latched.
// Throughput: a frame holds off new commands while it runs through the bit-serial shift
// chain and is latched; other commands run at one per cycle while the output is free.
// Reset (rst_n, asynchronous, active low): all lit words, blink masks and the
// phase clear, the controller returns to idle and no result beat is pending.
// ----------------------------------------------------------------------------
// LED blink shift driver core
// Keeps two LED banks and blink masks, applies commands and shifts frames.
// ----------------------------------------------------------------------------
module led_blink_shift_driver_core (
    input  logic        clk,
    input  logic        rst_n,
    lbsd_in_if.sink     cmd_in,
    lbsd_out_if.source  frame_out
);
    import lbsd_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       in_ready;

    // Controller: decides when a command beat is taken and paces the shift.
    lbsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_in.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    assign cmd_in.ready = in_ready;

    // Datapath: LED state, the serial frame chain and the result register.
    lbsd_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (cmd_in.data),
        .cmd    (cmd),
        .status (status),
        .result (frame_out)
    );

endmodule
